/* hw/rtl/scanline_irq_and_multiplier_core_macros.svh */
// Assertion helpers used by the core RTL.
`ifndef SCANLINE_IRQ_AND_MULTIPLIER_CORE_MACROS_SVH
`define SCANLINE_IRQ_AND_MULTIPLIER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLIRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SLIRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/slirq_pkg.sv */
`default_nettype none

package slirq_pkg;

  localparam int unsigned OpW       = 2;
  localparam int unsigned PpuAddrW  = 14;
  localparam int unsigned CpuAddrW  = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned ProdW     = 2 * DataW;

  typedef enum logic [OpW-1:0] {
    OP_PPU_READ  = 2'd0,
    OP_CPU_TICK  = 2'd1,
    OP_REG_WRITE = 2'd2,
    OP_REG_READ  = 2'd3
  } op_t;

  localparam logic [CpuAddrW-1:0] ADDR_TARGET = 16'h5203;
  localparam logic [CpuAddrW-1:0] ADDR_STATUS = 16'h5204;
  localparam logic [CpuAddrW-1:0] ADDR_MUL_LO = 16'h5205;
  localparam logic [CpuAddrW-1:0] ADDR_MUL_HI = 16'h5206;

  localparam int unsigned STAT_FRAME_BIT   = 6;
  localparam int unsigned STAT_PENDING_BIT = 7;
  localparam int unsigned ENABLE_BIT       = 7;

  localparam logic [1:0] IDLE_LIMIT  = 2'd3;
  localparam logic [1:0] MATCH_LIMIT = 2'd2;
  localparam logic [1:0] MATCH_SAT   = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/slirq_if.sv */
`default_nettype none

interface slirq_in_if;
  logic                                valid;
  logic                                ready;
  logic [slirq_pkg::OpW-1:0]           op;
  logic [slirq_pkg::PpuAddrW-1:0]      ppu_addr;
  logic                                nametable_fetch;
  logic [slirq_pkg::CpuAddrW-1:0]      cpu_addr;
  logic [slirq_pkg::DataW-1:0]         wdata;

  modport source (output valid, op, ppu_addr, nametable_fetch, cpu_addr, wdata,
                  input ready);
  modport sink   (input valid, op, ppu_addr, nametable_fetch, cpu_addr, wdata,
                  output ready);
endinterface

interface slirq_out_if;
  logic                          valid;
  logic                          ready;
  logic [slirq_pkg::DataW-1:0]   read_data;
  logic                          read_hit;
  logic                          irq_line;

  modport source (output valid, read_data, read_hit, irq_line, input ready);
  modport sink   (input valid, read_data, read_hit, irq_line, output ready);
endinterface

`default_nettype wire

/* hw/rtl/slirq_line_det.sv */
`default_nettype none

// Repeated-fetch detector: after two repeats of one nametable address,
// the next fetch starts a line.
module slirq_line_det (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               fetch_en,
  input  wire logic [slirq_pkg::PpuAddrW-1:0]     fetch_addr,
  output logic                                    line_start
);

  logic [1:0]                          match_cnt_r, match_cnt_nxt;
  logic [slirq_pkg::PpuAddrW-1:0]      last_addr_r, last_addr_nxt;
  logic                                last_vld_r, last_vld_nxt;
  logic [1:0]                          cnt_base;
  logic                                vld_base;
  logic                                repeat_hit;

  assign line_start = fetch_en && (match_cnt_r == slirq_pkg::MATCH_LIMIT);

  always_comb begin
    cnt_base      = line_start ? 2'd0 : match_cnt_r;
    vld_base      = line_start ? 1'b0 : last_vld_r;
    repeat_hit    = vld_base && (fetch_addr == last_addr_r) &&
                    (cnt_base != slirq_pkg::MATCH_SAT);
    match_cnt_nxt = match_cnt_r;
    last_addr_nxt = last_addr_r;
    last_vld_nxt  = last_vld_r;
    if (fetch_en) begin
      match_cnt_nxt = repeat_hit ? cnt_base + 2'd1 : cnt_base;
      last_addr_nxt = fetch_addr;
      last_vld_nxt  = 1'b1;
    end
  end

  // Reset state holds address 0 as a seen address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_cnt_r <= 2'd0;
      last_addr_r <= '0;
      last_vld_r  <= 1'b1;
    end else begin
      match_cnt_r <= match_cnt_nxt;
      last_addr_r <= last_addr_nxt;
      last_vld_r  <= last_vld_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/scanline_irq_and_multiplier_core.sv */
// Scanline detector, scanline interrupt and 8x8 multiplier.
// in_ch: one transfer per bus event: a PPU read (address, nametable flag),
//   a CPU tick, a CPU register write or a CPU register read.
// out_ch: exactly one transfer per input transfer, in order: read data and
//   hit flag for register reads (zero otherwise) and the interrupt level.
// The result is registered: it is valid the cycle after the input transfer.
// Throughput: one item per cycle; everything, including the 8x8 product,
//   is settled by the logic between the input handshake and the result
//   register. in_ch.ready stays high while the result register is empty or
//   being drained in the same cycle.
// Receiver stall: the result is held in place and in_ch.ready drops until
//   out_ch takes it; no state moves while stalled.
// Reset (synchronous, rst_n low): all counters, flags, target, enable and
//   operands clear; the result register empties. The detector treats
//   address zero as already seen.
// Writes: 0x5203 target, 0x5204 enable (bit 7), 0x5205/0x5206 operands.
// Reads:  0x5204 status (bit 6 in frame, bit 7 pending; clears pending),
//   0x5205/0x5206 product low/high byte.
`default_nettype none

`include "scanline_irq_and_multiplier_core_macros.svh"

module scanline_irq_and_multiplier_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  slirq_in_if.sink    in_ch,
  slirq_out_if.source out_ch
);

  localparam int unsigned DW = slirq_pkg::DataW;

  slirq_pkg::op_t             op;
  logic                       accept;
  logic                       in_ready;
  logic                       fetch_en;
  logic                       line_start;
  logic [slirq_pkg::ProdW-1:0] product;
  logic [1:0]                 idle_inc;

  logic          frame_on_r, frame_on_nxt;
  logic [DW-1:0] line_count_r, line_count_nxt;
  logic [1:0]    idle_ticks_r, idle_ticks_nxt;
  logic [DW-1:0] irq_target_r, irq_target_nxt;
  logic          irq_enable_r, irq_enable_nxt;
  logic          irq_pending_r, irq_pending_nxt;
  logic [DW-1:0] operand_a_r, operand_a_nxt;
  logic [DW-1:0] operand_b_r, operand_b_nxt;
  logic          irq_level_r, irq_level_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic          out_hit_r, out_hit_nxt;

  assign op       = slirq_pkg::op_t'(in_ch.op);
  assign in_ready = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ready;
  assign fetch_en = accept && (op == slirq_pkg::OP_PPU_READ) && in_ch.nametable_fetch;
  assign product  = operand_a_r * operand_b_r;
  assign idle_inc = (idle_ticks_r == slirq_pkg::IDLE_LIMIT) ? idle_ticks_r
                                                            : idle_ticks_r + 2'd1;

  slirq_line_det u_line_det (
    .clk        (clk),
    .rst_n      (rst_n),
    .fetch_en   (fetch_en),
    .fetch_addr (in_ch.ppu_addr),
    .line_start (line_start)
  );

  always_comb begin
    frame_on_nxt    = frame_on_r;
    line_count_nxt  = line_count_r;
    idle_ticks_nxt  = idle_ticks_r;
    irq_target_nxt  = irq_target_r;
    irq_enable_nxt  = irq_enable_r;
    irq_pending_nxt = irq_pending_r;
    operand_a_nxt   = operand_a_r;
    operand_b_nxt   = operand_b_r;
    irq_level_nxt   = irq_level_r;
    out_data_nxt    = '0;
    out_hit_nxt     = 1'b0;
    if (accept) begin
      case (op)
        slirq_pkg::OP_PPU_READ: begin
          idle_ticks_nxt = 2'd0;
          if (line_start) begin
            frame_on_nxt    = 1'b1;
            line_count_nxt  = frame_on_r ? line_count_r + 8'd1 : '0;
            irq_pending_nxt = (irq_target_r == line_count_nxt) && (irq_target_r != '0);
          end
        end
        slirq_pkg::OP_CPU_TICK: begin
          idle_ticks_nxt = idle_inc;
          if (idle_inc == slirq_pkg::IDLE_LIMIT) begin
            frame_on_nxt = 1'b0;
          end
          irq_level_nxt = irq_pending_r && irq_enable_r && (line_count_r != '0);
        end
        slirq_pkg::OP_REG_WRITE: begin
          if (in_ch.cpu_addr == slirq_pkg::ADDR_TARGET) begin
            irq_target_nxt = in_ch.wdata;
          end else if (in_ch.cpu_addr == slirq_pkg::ADDR_STATUS) begin
            irq_enable_nxt = in_ch.wdata[slirq_pkg::ENABLE_BIT];
          end else if (in_ch.cpu_addr == slirq_pkg::ADDR_MUL_LO) begin
            operand_a_nxt = in_ch.wdata;
          end else if (in_ch.cpu_addr == slirq_pkg::ADDR_MUL_HI) begin
            operand_b_nxt = in_ch.wdata;
          end
        end
        slirq_pkg::OP_REG_READ: begin
          if (in_ch.cpu_addr == slirq_pkg::ADDR_STATUS) begin
            out_hit_nxt = 1'b1;
            out_data_nxt[slirq_pkg::STAT_FRAME_BIT]   = frame_on_r;
            out_data_nxt[slirq_pkg::STAT_PENDING_BIT] = irq_pending_r;
            irq_pending_nxt = 1'b0;
          end else if (in_ch.cpu_addr == slirq_pkg::ADDR_MUL_LO) begin
            out_hit_nxt  = 1'b1;
            out_data_nxt = product[DW-1:0];
          end else if (in_ch.cpu_addr == slirq_pkg::ADDR_MUL_HI) begin
            out_hit_nxt  = 1'b1;
            out_data_nxt = product[2*DW-1:DW];
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_nxt = accept || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_on_r    <= 1'b0;
      line_count_r  <= '0;
      idle_ticks_r  <= 2'd0;
      irq_target_r  <= '0;
      irq_enable_r  <= 1'b0;
      irq_pending_r <= 1'b0;
      operand_a_r   <= '0;
      operand_b_r   <= '0;
      irq_level_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      frame_on_r    <= frame_on_nxt;
      line_count_r  <= line_count_nxt;
      idle_ticks_r  <= idle_ticks_nxt;
      irq_target_r  <= irq_target_nxt;
      irq_enable_r  <= irq_enable_nxt;
      irq_pending_r <= irq_pending_nxt;
      operand_a_r   <= operand_a_nxt;
      operand_b_r   <= operand_b_nxt;
      irq_level_r   <= irq_level_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload; loaded only on an input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      out_hit_r  <= out_hit_nxt;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.read_hit  = out_hit_r;
  // irq level only moves on a transfer, which also reloads the result.
  assign out_ch.irq_line  = irq_level_r;

  `SLIRQ_ASSERT_NEXT(a_status_read_clears, clk, rst_n,
    accept && (op == slirq_pkg::OP_REG_READ) && (in_ch.cpu_addr == slirq_pkg::ADDR_STATUS),
    !irq_pending_r)
  `SLIRQ_ASSERT_NEXT(a_level_only_on_tick, clk, rst_n,
    !(accept && (op == slirq_pkg::OP_CPU_TICK)), $stable(irq_level_r))
  `SLIRQ_ASSERT_NEXT(a_third_idle_tick_leaves, clk, rst_n,
    accept && (op == slirq_pkg::OP_CPU_TICK) && (idle_ticks_r != 2'd0) &&
    (idle_ticks_r != 2'd1), !frame_on_r)
  `SLIRQ_ASSERT_NOW(a_miss_reads_zero, clk, rst_n,
    out_valid_r && !out_hit_r, out_data_r == '0)

endmodule

`default_nettype wire

/* bench/scanline_irq_and_multiplier_core_checker.sv */
module scanline_irq_and_multiplier_core_checker
  import slirq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  slirq_in_if         in_mon,
  slirq_out_if        out_mon,
  output int unsigned mismatch_cnt,
  output int unsigned backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] NoFetchAddr = 16'hFFFF;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             read_hit;
    logic             irq_line;
  } bus_result_t;

  // Shadow copy of the block state
  logic             frame_on;
  logic [7:0]       line_cnt;
  logic [1:0]       match_cnt;
  logic [15:0]      last_nt_addr;
  logic [1:0]       idle_cnt;
  logic [7:0]       irq_tgt;
  logic             irq_en;
  logic             irq_pend;
  logic [DataW-1:0] mul_a;
  logic [DataW-1:0] mul_b;
  logic             irq_lvl;

  bus_result_t      results_q[$];
  int unsigned      err_cnt = 0;

  function automatic void clear_state();
    frame_on     = 1'b0;
    line_cnt     = '0;
    match_cnt    = '0;
    last_nt_addr = '0;
    idle_cnt     = '0;
    irq_tgt      = '0;
    irq_en       = 1'b0;
    irq_pend     = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    irq_lvl      = 1'b0;
  endfunction

  // Line detection on nametable fetches
  function automatic void track_fetch(input logic [15:0] addr);
    if (match_cnt == MATCH_LIMIT) begin
      if (!frame_on) begin
        frame_on = 1'b1;
        line_cnt = '0;
      end else begin
        line_cnt = line_cnt + 8'd1;
      end
      irq_pend     = (irq_tgt == line_cnt) && (irq_tgt != 8'd0);
      match_cnt    = '0;
      last_nt_addr = NoFetchAddr;
    end
    if (addr == last_nt_addr && match_cnt < MATCH_SAT) match_cnt = match_cnt + 2'd1;
    last_nt_addr = addr;
  endfunction

  function automatic bus_result_t bus_event(input op_t op,
                                            input logic [PpuAddrW-1:0] ppu_addr,
                                            input logic nt_fetch,
                                            input logic [CpuAddrW-1:0] cpu_addr,
                                            input logic [DataW-1:0] wdata);
    bus_result_t      r;
    logic [ProdW-1:0] prod;
    r    = '0;
    prod = mul_a * mul_b;
    case (op)
      OP_PPU_READ: begin
        idle_cnt = '0;
        if (nt_fetch) track_fetch({2'b00, ppu_addr});
      end
      OP_CPU_TICK: begin
        if (idle_cnt < IDLE_LIMIT) idle_cnt = idle_cnt + 2'd1;
        if (idle_cnt >= IDLE_LIMIT) frame_on = 1'b0;
        irq_lvl = irq_pend && irq_en && (line_cnt != 8'd0);
      end
      OP_REG_WRITE: begin
        if (cpu_addr == ADDR_TARGET) irq_tgt = wdata;
        else if (cpu_addr == ADDR_STATUS) irq_en = wdata[ENABLE_BIT];
        else if (cpu_addr == ADDR_MUL_LO) mul_a = wdata;
        else if (cpu_addr == ADDR_MUL_HI) mul_b = wdata;
      end
      OP_REG_READ: begin
        if (cpu_addr == ADDR_STATUS) begin
          r.read_hit                    = 1'b1;
          r.read_data[STAT_FRAME_BIT]   = frame_on;
          r.read_data[STAT_PENDING_BIT] = irq_pend;
          irq_pend                      = 1'b0;
        end else if (cpu_addr == ADDR_MUL_LO) begin
          r.read_hit  = 1'b1;
          r.read_data = prod[DataW-1:0];
        end else if (cpu_addr == ADDR_MUL_HI) begin
          r.read_hit  = 1'b1;
          r.read_data = prod[ProdW-1:DataW];
        end
      end
      default: ;
    endcase
    r.irq_line = irq_lvl;
    return r;
  endfunction

  always @(posedge clk) begin
    bus_result_t want;
    if (!rst_n) begin
      clear_state();
      results_q.delete();
    end else begin
      // result side first: it always belongs to an earlier input transfer
      if (out_mon.valid && out_mon.ready) begin
        if (results_q.size() == 0) begin
          $error("result transfer with nothing expected: read_data %0h read_hit %0b irq_line %0b",
                 out_mon.read_data, out_mon.read_hit, out_mon.irq_line);
          err_cnt++;
        end else begin
          want = results_q.pop_front();
          if (out_mon.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, out_mon.read_data);
            err_cnt++;
          end
          if (out_mon.read_hit !== want.read_hit) begin
            $error("read_hit: expected %0b, actual %0b", want.read_hit, out_mon.read_hit);
            err_cnt++;
          end
          if (out_mon.irq_line !== want.irq_line) begin
            $error("irq_line: expected %0b, actual %0b", want.irq_line, out_mon.irq_line);
            err_cnt++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        results_q.push_back(bus_event(op_t'(in_mon.op), in_mon.ppu_addr,
                                      in_mon.nametable_fetch, in_mon.cpu_addr,
                                      in_mon.wdata));
    end
    mismatch_cnt <= err_cnt;
    backlog      <= results_q.size();
  end

endmodule

/* bench/scanline_irq_and_multiplier_core_tb.sv */
// Stimulus and verdict for the scanline detector / IRQ / multiplier block.
// The checker instance predicts and compares; this module only drives
// transfers, stalls the result side and decides pass or fail.
module scanline_irq_and_multiplier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slirq_pkg::*;

  // Cycles without any transfer on either channel before the run is called hung.
  // Worst legitimate quiet stretch is a long input gap next to a long result
  // stall.
  localparam int unsigned StallLimit  = 2000;
  // Random stimulus starts no new frame once this many input transfers have been sent.
  localparam int unsigned RandomItems = 550;

  typedef struct packed {
    op_t                 op;
    logic [PpuAddrW-1:0] ppu_addr;
    logic                nt_fetch;
    logic [CpuAddrW-1:0] cpu_addr;
    logic [DataW-1:0]    wdata;
  } bus_item_t;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned results_due;
  int unsigned quiet_cycles;
  int unsigned item_cnt;
  logic        stuck;
  bit          in_calm;   // when set, the sender never idles

  slirq_in_if  in_ch ();
  slirq_out_if out_ch ();

  scanline_irq_and_multiplier_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scanline_irq_and_multiplier_core_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatch_cnt (mismatches),
    .backlog      (results_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: any transfer on either side resets the count.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end
  assign stuck = (quiet_cycles >= StallLimit);

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Operand / data byte with the extremes weighted in.
  function automatic logic [DataW-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return DataW'($urandom());
    endcase
  endfunction

  // Every field gets random content; the caller overrides what matters.
  function automatic bus_item_t random_fields(input op_t op);
    bus_item_t it;
    it.op       = op;
    it.ppu_addr = PpuAddrW'($urandom());
    it.nt_fetch = 1'($urandom_range(0, 1));
    it.cpu_addr = CpuAddrW'($urandom());
    it.wdata    = DataW'($urandom());
    return it;
  endfunction

  // Present one item and hold it until the transfer; then maybe idle.
  // valid is only lowered when a gap follows, so back-to-back items keep it
  // high without a second assignment in the same step.
  task automatic send_item(input bus_item_t it);
    int unsigned gap;
    in_ch.valid           <= 1'b1;
    in_ch.op              <= it.op;
    in_ch.ppu_addr        <= it.ppu_addr;
    in_ch.nametable_fetch <= it.nt_fetch;
    in_ch.cpu_addr        <= it.cpu_addr;
    in_ch.wdata           <= it.wdata;
    do @(posedge clk); while (!in_ch.ready);
    item_cnt++;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic ppu_read(input logic [PpuAddrW-1:0] addr, input logic nt);
    bus_item_t it;
    it          = random_fields(OP_PPU_READ);
    it.ppu_addr = addr;
    it.nt_fetch = nt;
    send_item(it);
  endtask

  task automatic cpu_tick();
    send_item(random_fields(OP_CPU_TICK));
  endtask

  task automatic reg_write(input logic [CpuAddrW-1:0] addr, input logic [DataW-1:0] data);
    bus_item_t it;
    it          = random_fields(OP_REG_WRITE);
    it.cpu_addr = addr;
    it.wdata    = data;
    send_item(it);
  endtask

  task automatic reg_read(input logic [CpuAddrW-1:0] addr);
    bus_item_t it;
    it          = random_fields(OP_REG_READ);
    it.cpu_addr = addr;
    send_item(it);
  endtask

  // Any op, addresses near the register window or anywhere on the bus.
  task automatic noise_item();
    bus_item_t it;
    it = random_fields(op_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 2) != 0)
      it.cpu_addr = ADDR_TARGET - 16'd1 + CpuAddrW'($urandom_range(0, 5));
    send_item(it);
  endtask

  // Background traffic dropped between fetches: reads, writes, one or two
  // ticks (never three, so the frame survives), stray PPU reads.
  task automatic side_traffic();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      // nothing
    end else if (r < 60) begin
      ppu_read(PpuAddrW'($urandom()), 1'b0);
    end else if (r < 70) begin
      cpu_tick();
      if ($urandom_range(0, 1)) cpu_tick();
    end else if (r < 78) begin
      reg_read(ADDR_STATUS);
    end else if (r < 84) begin
      reg_read($urandom_range(0, 1) ? ADDR_MUL_LO : ADDR_MUL_HI);
    end else if (r < 89) begin
      reg_write($urandom_range(0, 1) ? ADDR_MUL_LO : ADDR_MUL_HI, pick_byte());
    end else if (r < 93) begin
      if ($urandom_range(0, 1)) reg_write(ADDR_TARGET, DataW'($urandom_range(0, 15)));
      else reg_write(ADDR_STATUS, pick_byte());
    end else begin
      noise_item();
    end
  endtask

  // One scanline: three nametable fetches at one address. The first of
  // them also closes the previous line once the match count is full.
  // Broken lines drop a fetch or slip in a different address.
  task automatic scan_line(input logic [PpuAddrW-1:0] addr, input bit busy);
    int unsigned shape;
    shape = $urandom_range(0, 19);
    for (int i = 0; i < 3; i++) begin
      if (shape == 0 && i == 2) continue;                 // short line
      if (shape == 1 && i == 1) ppu_read(addr ^ 14'h1, 1'b1); // stray address
      ppu_read(addr, 1'b1);
      if (busy) side_traffic();
      else if ($urandom_range(0, 19) == 0) side_traffic();
    end
  endtask

  // Three or more ticks with no PPU read in between: frame ends, idle
  // count saturates; status reads in the middle do not reset it.
  task automatic end_frame();
    int unsigned n;
    n = $urandom_range(3, 5);
    for (int i = 0; i < n; i++) begin
      cpu_tick();
      if ($urandom_range(0, 3) == 0) reg_read(ADDR_STATUS);
    end
    reg_read(ADDR_STATUS);
  endtask

  // Register writes opening a frame; target often small so it gets hit.
  task automatic frame_setup();
    logic [DataW-1:0] tgt;
    case ($urandom_range(0, 5))
      0:       tgt = '0;
      1:       tgt = '1;
      default: tgt = DataW'($urandom_range(1, 14));
    endcase
    if ($urandom_range(0, 3) != 0) reg_write(ADDR_TARGET, tgt);
    if ($urandom_range(0, 2) != 0) reg_write(ADDR_STATUS, DataW'($urandom()));
    if ($urandom_range(0, 1)) reg_write(ADDR_MUL_LO, pick_byte());
    if ($urandom_range(0, 1)) reg_write(ADDR_MUL_HI, pick_byte());
  endtask

  task automatic run_directed();
    // Reset values: status clear, product of zero operands
    reg_read(ADDR_STATUS);
    reg_read(ADDR_MUL_LO);
    // Largest product 0xFF * 0xFF = 0xFE01
    reg_write(ADDR_MUL_LO, 8'hFF);
    reg_write(ADDR_MUL_HI, 8'hFF);
    reg_read(ADDR_MUL_LO);
    reg_read(ADDR_MUL_HI);
    reg_write(ADDR_TARGET, 8'd1);
    reg_write(ADDR_STATUS, 8'h80);
    // Address zero counts as already seen after reset, so two fetches
    // at zero fill the match count; the first of the next four fetches enters
    // the frame at line 0, and the fourth makes line 1 hit the target.
    ppu_read('0, 1'b1);
    ppu_read('0, 1'b1);
    repeat (4) ppu_read('1, 1'b1);
    cpu_tick();                  // irq rises
    reg_read(ADDR_STATUS);       // in frame + pending, clears pending
    cpu_tick();                  // irq falls on this tick, not before
    ppu_read(PpuAddrW'($urandom()), 1'b0);  // plain PPU read clears the idle count
    repeat (4) cpu_tick();       // leave the frame, idle count saturates
    reg_read(ADDR_STATUS);
    // Unmapped write and reads, write-only target register
    reg_write(16'h0000, 8'hFF);
    reg_read(16'hFFFF);
    reg_read(ADDR_TARGET);
    reg_write(ADDR_STATUS, 8'h7F);  // enable bit low
  endtask

  task automatic run_random();
    int unsigned lines;
    logic [PpuAddrW-1:0] addr;
    while (item_cnt < RandomItems) begin
      in_calm = ($urandom_range(0, 3) == 0);
      frame_setup();
      lines = $urandom_range(1, 14);
      addr  = PpuAddrW'($urandom());
      for (int l = 0; l < lines; l++) begin
        // usually a fresh address per line, sometimes the same one again
        if ($urandom_range(0, 3) != 0) addr = PpuAddrW'($urandom());
        scan_line(addr, 1'b1);
      end
      if ($urandom_range(0, 4) != 0) end_frame();
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) noise_item();
    end
    in_calm = 1'b0;
  endtask

  // Result side: bursts of ready, mostly short gaps, a few long ones, and
  // occasionally a long burst with no stall at all.
  initial begin
    int unsigned burst;
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    item_cnt              = 0;
    in_calm               = 1'b0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.op              <= OP_PPU_READ;
    in_ch.ppu_addr        <= '0;
    in_ch.nametable_fetch <= 1'b0;
    in_ch.cpu_addr        <= '0;
    in_ch.wdata           <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        run_directed();
        run_random();
        in_ch.valid <= 1'b0;
        // let the registered backlog take in the last transfer first
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (8) @(posedge clk);
      end
      wait (stuck);
    join_any

    if (!stuck && mismatches == 0) begin
      $display("** scanline_irq_and_multiplier_core: PASSED **");
    end else begin
      $display("** scanline_irq_and_multiplier_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/slirq_pkg.sv
hw/rtl/slirq_if.sv
hw/rtl/slirq_line_det.sv
hw/rtl/scanline_irq_and_multiplier_core.sv
bench/scanline_irq_and_multiplier_core_checker.sv
bench/scanline_irq_and_multiplier_core_tb.sv
